// File: src/rpc_pkg.sv
// Shared types, constants and helpers for the rational polynomial camera core.
// No dependencies; every other file of the block imports this package.
package rpc_pkg;

  localparam int NUM_TERMS   = 20;
  localparam int TABLE_DEPTH = 90;
  localparam int COEF_SLOTS  = 4 * NUM_TERMS;
  localparam int MONO_STEPS  = 16;

  // Axis k has its scale at SCALE_BASE + 2k and its offset one slot above.
  localparam logic [6:0] SCALE_BASE = 7'd80;
  localparam logic [6:0] U_SCALE    = 7'd86;
  localparam logic [6:0] U_OFFSET   = 7'd87;
  localparam logic [6:0] V_SCALE    = 7'd88;
  localparam logic [6:0] V_OFFSET   = 7'd89;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PROJECT = 1'b1;

  localparam logic CFG_WORLD_SCALE = 1'b0;
  localparam logic CFG_IMAGE_SCALE = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Fixed monomial slots that hold a plain coordinate or the constant term.
  localparam logic [4:0] MONO_X   = 5'd9;
  localparam logic [4:0] MONO_Y   = 5'd15;
  localparam logic [4:0] MONO_Z   = 5'd18;
  localparam logic [4:0] MONO_ONE = 5'd19;

  typedef struct packed {
    logic              action;
    logic [6:0]        table_index;
    logic signed [31:0] table_word;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] image_u;
    logic signed [31:0] image_v;
    logic               div_error;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [1:0] a;       // coordinate operand
    logic       b_mono;  // second operand comes from the monomial file
    logic [4:0] b;       // coordinate code or monomial slot
    logic [4:0] dest;    // monomial slot written
  } mono_step_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NSC, ST_NOF, ST_NDV, ST_NWT, ST_MONO, ST_MAC, ST_MDRN, ST_CHK,
    ST_DU, ST_DV, ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if ((&v[63:31]) || !(|v[63:31])) return v[31:0];
    return v[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  // Products in issue order: second-degree terms first, then the cubic ones.
  function automatic mono_step_t mono_step(input logic [3:0] j);
    mono_step_t s;
    case (j)
      4'd0:    s = '{AX_X, 1'b0, 5'(AX_X), 5'd3};
      4'd1:    s = '{AX_X, 1'b0, 5'(AX_Y), 5'd6};
      4'd2:    s = '{AX_X, 1'b0, 5'(AX_Z), 5'd8};
      4'd3:    s = '{AX_Y, 1'b0, 5'(AX_Y), 5'd12};
      4'd4:    s = '{AX_Y, 1'b0, 5'(AX_Z), 5'd14};
      4'd5:    s = '{AX_Z, 1'b0, 5'(AX_Z), 5'd17};
      4'd6:    s = '{AX_X, 1'b1, 5'd3,  5'd0};
      4'd7:    s = '{AX_X, 1'b1, 5'd6,  5'd1};
      4'd8:    s = '{AX_X, 1'b1, 5'd8,  5'd2};
      4'd9:    s = '{AX_X, 1'b1, 5'd12, 5'd4};
      4'd10:   s = '{AX_X, 1'b1, 5'd14, 5'd5};
      4'd11:   s = '{AX_X, 1'b1, 5'd17, 5'd7};
      4'd12:   s = '{AX_Y, 1'b1, 5'd12, 5'd10};
      4'd13:   s = '{AX_Y, 1'b1, 5'd14, 5'd11};
      4'd14:   s = '{AX_Y, 1'b1, 5'd17, 5'd13};
      default: s = '{AX_Z, 1'b1, 5'd17, 5'd16};
    endcase
    return s;
  endfunction

endpackage

// File: src/rpc_table.sv
// Parameter table: 90 words with one write port and one registered read port.
// Depends on rpc_pkg for the table depth.
module rpc_table import rpc_pkg::*; (
  input  logic        clk,
  input  logic        we,
  input  logic [6:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [6:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [0:TABLE_DEPTH-1];

  // Writes beyond the last slot are dropped.
  always_ff @(posedge clk) begin
    if (we && (waddr < 7'(TABLE_DEPTH))) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/rpc_div.sv
// Restoring divider, one quotient bit per cycle: (num * 2^16) / den in Q16.16,
// truncated toward zero and saturated to 32 bits. Depends on rpc_pkg.
module rpc_div import rpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DVD_W = 80;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [63:0]      dsr;
  logic [63:0]      rem;
  logic [31:0]      q;
  logic             ovf;
  logic             neg;
  logic [63:0]      a_mag;
  logic [63:0]      b_mag;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_sub;
  logic             fits;
  logic [31:0]      lim;
  logic [31:0]      q_sat;

  assign a_mag   = req.num[63] ? 64'(-req.num) : req.num;
  assign b_mag   = req.den[63] ? 64'(-req.den) : req.den;
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = !rem_sub[64];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(DVD_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      dvd <= {a_mag, 16'b0};
      dsr <= b_mag;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      neg <= req.num[63] ^ req.den[63];
    end else if (busy) begin
      rem <= fits ? rem_sub[63:0] : rem_sh[63:0];
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      q   <= {q[30:0], fits};
      ovf <= ovf | q[31];
      cnt <= cnt + 1'b1;
    end
  end

  // A negative result may reach -2^31, a positive one only 2^31 - 1.
  always_comb begin
    lim   = neg ? 32'h80000000 : 32'h7FFFFFFF;
    q_sat = (ovf || (q > lim)) ? lim : q;
    rsp.done = done;
    rsp.quot = neg ? -q_sat : q_sat;
  end

endmodule

// File: src/rational_poly_camera_projection_core.sv
// Rational polynomial camera core: sequencer, shared multiplier and accumulator.
// Depends on rpc_pkg, rpc_table and rpc_div.
//
// Usage. Items arrive on the in channel as valid/ready transactions. A load
// transaction (action 0) writes one word of the parameter table in the cycle
// it is accepted and produces nothing. A project transaction (action 1) yields
// exactly one transaction on the out channel: image u, v and the error flag.
// One item is worked on at a time; ready is high only while the sequencer is
// idle. A projection's result waits on the shared divider, which produces one
// bit of an 80-bit dividend per cycle and is used twice for u and v plus once
// per axis when world normalisation is enabled, and on the 80 coefficient
// reads from the single table port.
// The result sits in an output register, so once it is stored the core goes
// idle and accepts the next transaction while the receiver stalls; a second
// result waits in the sequencer until the register is free.
// Reset clears the sequencer, the output valid and both enable registers; the
// table is not cleared and every slot must be loaded before it is used.
// The enables are written through the plain cfg port; the user must write
// them only while the core is idle, and the core itself does not enforce this.
module rational_poly_camera_projection_core import rpc_pkg::*; #(
  parameter int COEF_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_data
);

  // Only the low coefficient bits of a table word are used, sign extended.
  localparam int CW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;

  state_t state, state_next;

  logic               wse;
  logic               ise;
  logic               in_fire;
  logic               err;
  logic [1:0]         ax;
  logic [3:0]         mstep;
  mono_step_t         cur;
  logic               wb_valid;
  logic [4:0]         wb_dest;
  logic [6:0]         cnt;
  logic [4:0]         kk;
  logic [1:0]         rr;
  logic               s1_valid;
  logic [4:0]         s1_k;
  logic [1:0]         s1_r;
  logic               s2_valid;
  logic [4:0]         s2_k;
  logic [1:0]         s2_r;
  logic signed [31:0] px, py, pz;
  logic signed [31:0] pa, pb, pn;
  logic signed [31:0] sc_reg;
  logic signed [31:0] u_reg, v_reg;
  logic signed [31:0] mono [0:NUM_TERMS-1];
  logic [4:0]         mono_raddr;
  logic signed [31:0] mono_rd;
  logic signed [63:0] sum [0:3];
  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [6:0]         tab_raddr;
  logic [31:0]        tab_rdata;
  logic signed [31:0] rdata_s;
  logic signed [31:0] coef_ext;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rdata_s  = signed'(tab_rdata);
  assign coef_ext = 32'(signed'(tab_rdata[CW-1:0]));
  assign cur      = mono_step(mstep);

  rpc_table u_table (
    .clk   (clk),
    .we    (in_fire && (in_data.action == ACT_LOAD)),
    .waddr (in_data.table_index),
    .wdata (in_data.table_word),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  rpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Coordinate selection for the monomial products and for normalisation.
  always_comb begin
    case (cur.a)
      AX_X:    pa = px;
      AX_Y:    pa = py;
      default: pa = pz;
    endcase
    case (cur.b[1:0])
      AX_X:    pb = px;
      AX_Y:    pb = py;
      default: pb = pz;
    endcase
    case (ax)
      AX_X:    pn = px;
      AX_Y:    pn = py;
      default: pn = pz;
    endcase
  end

  // The monomial file has a single read port, shared by the two phases.
  assign mono_raddr = (state == ST_MONO) ? cur.b : s1_k;
  assign mono_rd    = mono[mono_raddr];

  always_comb begin
    case (state)
      ST_MONO: begin
        mul_a = pa;
        mul_b = cur.b_mono ? mono_rd : pb;
      end
      ST_I1: begin
        mul_a = u_reg;
        mul_b = rdata_s;
      end
      ST_I3: begin
        mul_a = v_reg;
        mul_b = rdata_s;
      end
      default: begin
        mul_a = coef_ext;
        mul_b = mono_rd;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // Next state, table read address and divider requests.
  always_comb begin
    state_next = state;
    tab_raddr  = cnt;
    div_req    = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire && (in_data.action == ACT_PROJECT)) begin
          state_next = wse ? ST_NSC : ST_MONO;
        end
      end
      ST_NSC: begin
        tab_raddr  = SCALE_BASE + 7'({ax, 1'b0});
        state_next = ST_NOF;
      end
      ST_NOF: begin
        tab_raddr  = SCALE_BASE + 7'({ax, 1'b1});
        state_next = ST_NDV;
      end
      ST_NDV: begin
        if (sc_reg == 32'sd0) begin
          state_next = (ax == AX_Z) ? ST_MONO : ST_NSC;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = 64'(pn) - 64'(rdata_s);
          div_req.den   = 64'(sc_reg);
          state_next    = ST_NWT;
        end
      end
      ST_NWT: begin
        if (div_rsp.done) begin
          state_next = (ax == AX_Z) ? ST_MONO : ST_NSC;
        end
      end
      ST_MONO: begin
        if (mstep == 4'(MONO_STEPS - 1)) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt == 7'(COEF_SLOTS - 1)) begin
          state_next = ST_MDRN;
        end
      end
      ST_MDRN: begin
        if (s2_valid && (s2_r == 2'd3) && (s2_k == 5'(NUM_TERMS - 1))) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (err || (sum[1] == 64'sd0) || (sum[3] == 64'sd0)) begin
          state_next = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = sum[0];
          div_req.den   = sum[1];
          state_next    = ST_DU;
        end
      end
      ST_DU: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = sum[2];
          div_req.den   = sum[3];
          state_next    = ST_DV;
        end
      end
      ST_DV: begin
        if (div_rsp.done) begin
          state_next = ise ? ST_I0 : ST_DONE;
        end
      end
      ST_I0: begin
        tab_raddr  = U_SCALE;
        state_next = ST_I1;
      end
      ST_I1: begin
        tab_raddr  = U_OFFSET;
        state_next = ST_I2;
      end
      ST_I2: begin
        tab_raddr  = V_SCALE;
        state_next = ST_I3;
      end
      ST_I3: begin
        tab_raddr  = V_OFFSET;
        state_next = ST_I4;
      end
      ST_I4: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control flags and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      wse       <= 1'b0;
      ise       <= 1'b0;
      out_valid <= 1'b0;
      wb_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WORLD_SCALE: wse <= cfg_data;
          CFG_IMAGE_SCALE: ise <= cfg_data;
          default: ;
        endcase
      end
      wb_valid <= (state == ST_MONO);
      s1_valid <= (state == ST_MAC);
      s2_valid <= s1_valid;
      if ((state == ST_DONE) && (state_next == ST_IDLE)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Each term is floored from Q.39 to Q.32 before it enters the row sum.
  assign acc_next = ((s2_k == 5'd0) ? 64'sd0 : acc) + (prod >>> 7);

  // Datapath registers.
  always_ff @(posedge clk) begin
    wb_dest <= cur.dest;
    s1_k    <= kk;
    s1_r    <= rr;
    s2_k    <= s1_k;
    s2_r    <= s1_r;
    if (wb_valid) begin
      mono[wb_dest] <= sat32(prod >>> 16);
    end
    if (s2_valid) begin
      acc <= acc_next;
      if (s2_k == 5'(NUM_TERMS - 1)) begin
        sum[s2_r] <= acc_next;
      end
    end
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          px    <= in_data.world_x;
          py    <= in_data.world_y;
          pz    <= in_data.world_z;
          err   <= 1'b0;
          ax    <= AX_X;
          mstep <= '0;
          cnt   <= '0;
          kk    <= '0;
          rr    <= '0;
        end
      end
      ST_NOF: begin
        sc_reg <= rdata_s;
      end
      ST_NDV: begin
        if (sc_reg == 32'sd0) begin
          err <= 1'b1;
          case (ax)
            AX_X:    px <= '0;
            AX_Y:    py <= '0;
            default: pz <= '0;
          endcase
          ax <= ax + 1'b1;
        end
      end
      ST_NWT: begin
        if (div_rsp.done) begin
          case (ax)
            AX_X:    px <= div_rsp.quot;
            AX_Y:    py <= div_rsp.quot;
            default: pz <= div_rsp.quot;
          endcase
          ax <= ax + 1'b1;
        end
      end
      ST_MONO: begin
        mstep          <= mstep + 1'b1;
        mono[MONO_X]   <= px;
        mono[MONO_Y]   <= py;
        mono[MONO_Z]   <= pz;
        mono[MONO_ONE] <= ONE_Q16;
      end
      ST_MAC: begin
        cnt <= cnt + 1'b1;
        if (kk == 5'(NUM_TERMS - 1)) begin
          kk <= '0;
          rr <= rr + 1'b1;
        end else begin
          kk <= kk + 1'b1;
        end
      end
      ST_CHK: begin
        if ((sum[1] == 64'sd0) || (sum[3] == 64'sd0)) begin
          err <= 1'b1;
        end
      end
      ST_DU: begin
        if (div_rsp.done) begin
          u_reg <= div_rsp.quot;
        end
      end
      ST_DV: begin
        if (div_rsp.done) begin
          v_reg <= div_rsp.quot;
        end
      end
      ST_I2: begin
        u_reg <= sat32((prod >>> 16) + 64'(rdata_s));
      end
      ST_I4: begin
        v_reg <= sat32((prod >>> 16) + 64'(rdata_s));
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.image_u   <= err ? 32'sd0 : u_reg;
          out_data.image_v   <= err ? 32'sd0 : v_reg;
          out_data.div_error <= err;
        end
      end
      default: ;
    endcase
  end

  // An error result always carries zero coordinates.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.div_error |-> (out_data.image_u == 32'sd0) &&
                                        (out_data.image_v == 32'sd0))
    else $error("error result with non-zero coordinates");

  // A projection transaction closes the input until its result is stored.
  a_proj_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.action == ACT_PROJECT) |=> !in_ready)
    else $error("input accepted during a projection");

  // Accumulator terms only arrive while the coefficient sweep is running.
  a_mac_phase: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == ST_MAC) || (state == ST_MDRN))
    else $error("accumulator term outside the coefficient sweep");

endmodule
